// ===== rtl/mtbs_pkg.sv =====
// Shared constants and types for the Manchester transmitter with bit stuffing.
package mtbs_pkg;

    localparam int LEVEL_W       = 16;
    localparam int BYTE_W        = 8;
    localparam int BIT_IDX_W     = $clog2(BYTE_W);
    localparam int MAX_RESULTS   = 10;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int RUN_LIMIT_DEF = 7;
    localparam int CFG_IDX_W     = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_LEVEL = 1'b0,
        REG_LOW_LEVEL  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              in_preamble;
        logic              end_of_frame;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } queue_head_t;

endpackage

// ===== rtl/mtbs_front.sv =====
// Front end: accepts byte requests and holds them in a two-entry queue.
module mtbs_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mtbs_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           in_preamble,
    input  logic                           end_of_frame,
    output mtbs_pkg::queue_head_t          head,
    input  logic                           pop
);

    mtbs_pkg::req_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           push;
    logic           do_pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (cnt_reg != 2'd0);

    assign head.valid = (cnt_reg != 2'd0);
    assign head.req   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{data_byte: data_byte, in_preamble: in_preamble,
                                     end_of_frame: end_of_frame};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/mtbs_back.sv =====
// Back end: walks a byte one symbol per cycle unless stalled, stuffs, registers each result.
module mtbs_back #(
    parameter int RUN_LIMIT = mtbs_pkg::RUN_LIMIT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mtbs_pkg::queue_head_t          head,
    output logic                           pop,
    input  logic [mtbs_pkg::LEVEL_W-1:0]   high_level,
    input  logic [mtbs_pkg::LEVEL_W-1:0]   low_level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mtbs_pkg::LEVEL_W-1:0]   first_half_level,
    output logic [mtbs_pkg::LEVEL_W-1:0]   second_half_level,
    output logic                           bit_value,
    output logic                           is_stuffing,
    output logic                           last,
    output logic                           line_idle_after
);

    localparam int RUN_W = $clog2(RUN_LIMIT + 1);
    localparam logic [RUN_W-1:0] RunMax = RUN_W'(RUN_LIMIT);
    localparam logic [mtbs_pkg::BIT_IDX_W-1:0] LastIdx = mtbs_pkg::BIT_IDX_W'(mtbs_pkg::BYTE_W - 1);
    localparam logic [mtbs_pkg::CNT_W-1:0] CntMax = mtbs_pkg::CNT_W'(mtbs_pkg::MAX_RESULTS);
    localparam logic [mtbs_pkg::CNT_W-1:0] CntLast = mtbs_pkg::CNT_W'(mtbs_pkg::MAX_RESULTS - 1);

    logic                              busy_reg;
    logic                              busy_next;
    logic [mtbs_pkg::BYTE_W-1:0]       byte_reg;
    logic [mtbs_pkg::BYTE_W-1:0]       byte_next;
    logic                              pre_reg;
    logic                              pre_next;
    logic                              eof_reg;
    logic                              eof_next;
    logic [mtbs_pkg::BIT_IDX_W-1:0]    idx_reg;
    logic [mtbs_pkg::BIT_IDX_W-1:0]    idx_next;
    logic [mtbs_pkg::CNT_W-1:0]        cnt_reg;
    logic [mtbs_pkg::CNT_W-1:0]        cnt_next;
    logic [RUN_W-1:0]                  run_reg;
    logic [RUN_W-1:0]                  run_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [mtbs_pkg::LEVEL_W-1:0]      first_reg;
    logic [mtbs_pkg::LEVEL_W-1:0]      second_reg;
    logic                              bit_reg;
    logic                              stuff_reg;
    logic                              last_reg;
    logic                              idle_reg;

    logic                              out_ready;
    logic                              step;
    logic                              stuff_now;
    logic                              sym_bit;
    logic                              final_sym;
    logic                              emit;
    logic                              load;
    logic                              sym_last;

    assign out_ready = !out_valid_reg || !out_stall;
    assign step      = busy_reg && out_ready;
    assign stuff_now = !pre_reg && (run_reg >= RunMax);
    assign sym_bit   = stuff_now ? 1'b0 : byte_reg[mtbs_pkg::BYTE_W-1];
    assign final_sym = !stuff_now && (idx_reg == LastIdx);
    assign emit      = (cnt_reg != CntMax);
    assign sym_last  = final_sym || (cnt_reg == CntLast);
    assign load      = head.valid && (!busy_reg || (step && final_sym));
    assign pop       = load;

    always_comb
    begin
        busy_next = busy_reg;
        byte_next = byte_reg;
        pre_next  = pre_reg;
        eof_next  = eof_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;

        if (step)
        begin
            if (stuff_now)
            begin
                run_next = '0;
            end
            else
            begin
                if (byte_reg[mtbs_pkg::BYTE_W-1])
                begin
                    if (run_reg < RunMax)
                    begin
                        run_next = run_reg + RUN_W'(1);
                    end
                end
                else
                begin
                    run_next = '0;
                end
                if (final_sym && eof_reg)
                begin
                    run_next = '0;
                end
                byte_next = {byte_reg[mtbs_pkg::BYTE_W-2:0], 1'b0};
                idx_next  = idx_reg + mtbs_pkg::BIT_IDX_W'(1);
            end
            if (emit)
            begin
                cnt_next = cnt_reg + mtbs_pkg::CNT_W'(1);
            end
            if (final_sym)
            begin
                busy_next = 1'b0;
            end
        end

        if (load)
        begin
            busy_next = 1'b1;
            byte_next = head.req.data_byte;
            pre_next  = head.req.in_preamble;
            eof_next  = head.req.end_of_frame;
            idx_next  = '0;
            cnt_next  = '0;
        end

        if (step)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            first_reg  <= sym_bit ? low_level : high_level;
            second_reg <= sym_bit ? high_level : low_level;
            bit_reg    <= sym_bit;
            stuff_reg  <= stuff_now;
            last_reg   <= sym_last;
            idle_reg   <= sym_last && eof_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        pre_reg  <= pre_next;
        eof_reg  <= eof_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign first_half_level  = first_reg;
    assign second_half_level = second_reg;
    assign bit_value         = bit_reg;
    assign is_stuffing       = stuff_reg;
    assign last              = last_reg;
    assign line_idle_after   = idle_reg;

endmodule

// ===== rtl/manchester_tx_bit_stuffing.sv =====
// Top level of the Manchester transmitter with bit stuffing: level registers, front and back end.
// An accepted byte goes through the queue and the back-end byte register to the output registers.
// Line bits then follow at one per cycle unless stalled, set by the back-end symbol sequencer.
// A byte gives eight line bits, plus one for each stuffing zero, at most ten results per byte.
// A two-entry request queue lets new bytes be accepted while a byte is still being sent.
// Reset clears the queue, the ones-run counter and the output valid, and restores the levels.
module manchester_tx_bit_stuffing #(
    parameter int RUN_LIMIT = mtbs_pkg::RUN_LIMIT_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [mtbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtbs_pkg::LEVEL_W-1:0]     cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mtbs_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             in_preamble,
    input  logic                             end_of_frame,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mtbs_pkg::LEVEL_W-1:0]     first_half_level,
    output logic [mtbs_pkg::LEVEL_W-1:0]     second_half_level,
    output logic                             bit_value,
    output logic                             is_stuffing,
    output logic                             last,
    output logic                             line_idle_after
);

    logic [mtbs_pkg::LEVEL_W-1:0] high_level_reg;
    logic [mtbs_pkg::LEVEL_W-1:0] low_level_reg;
    mtbs_pkg::queue_head_t        head;
    logic                         pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_level_reg <= {mtbs_pkg::LEVEL_W{1'b1}};
            low_level_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (mtbs_pkg::cfg_reg_t'(cfg_index))
                mtbs_pkg::REG_HIGH_LEVEL: high_level_reg <= cfg_wdata;
                mtbs_pkg::REG_LOW_LEVEL:  low_level_reg  <= cfg_wdata;
                default:                  high_level_reg <= high_level_reg;
            endcase
        end
    end

    mtbs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .in_preamble  (in_preamble),
        .end_of_frame (end_of_frame),
        .head         (head),
        .pop          (pop)
    );

    mtbs_back #(
        .RUN_LIMIT (RUN_LIMIT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .pop               (pop),
        .high_level        (high_level_reg),
        .low_level         (low_level_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .first_half_level  (first_half_level),
        .second_half_level (second_half_level),
        .bit_value         (bit_value),
        .is_stuffing       (is_stuffing),
        .last              (last),
        .line_idle_after   (line_idle_after)
    );

endmodule
